@@ hw/rtl/mrsl_pkg.sv @@
// Motor run sample logger: shared types, codes and helper functions.
// Used by mrsl_ctrl, mrsl_store and motor_run_sample_logger_top.
// No dependencies.
package mrsl_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MEAS = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_BRAKE = 2'd1;
	localparam logic [1:0] CMD_LEFT  = 2'd2;

	localparam logic [1:0] REG_INTERVAL = 2'd0;
	localparam logic [1:0] REG_STARTUP  = 2'd1;
	localparam logic [1:0] REG_LIMIT    = 2'd2;

	localparam logic [31:0] INTERVAL_RST = 32'd500;
	localparam logic [31:0] STARTUP_RST  = 32'd100000;
	localparam logic [11:0] LIMIT_RST    = 12'd2000;

	localparam logic [30:0] DELTA_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        tick_time;
		logic signed [31:0] cart_position;
		logic               left_switch;
		logic               right_switch;
		logic [10:0]        read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  motor_command;
		logic [1:0]  phase;
		logic        sample_stored;
		logic [11:0] sample_count;
		logic        read_valid;
		logic [31:0] read_time;
		logic [30:0] read_delta;
	} rsp_t;

	typedef struct packed {
		logic [31:0] tick_time;
		logic [30:0] delta;
	} entry_t;

	typedef struct packed {
		logic [1:0]  motor_command;
		logic [1:0]  phase;
		logic        sample_stored;
		logic [11:0] sample_count;
		logic        read_valid;
	} meta_t;

	// magnitude of the wrapped 32-bit difference
	function automatic logic [31:0] time_dist(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31] ? (32'd0 - d) : d;
	endfunction

	// exact magnitude of a signed difference, saturated
	function automatic logic [30:0] pos_change(input logic [31:0] now_pos,
		input logic [31:0] old_pos);
		logic [32:0] d;
		logic [32:0] m;
		d = {now_pos[31], now_pos} - {old_pos[31], old_pos};
		m = d[32] ? (33'd0 - d) : d;
		return (m > {2'b00, DELTA_MAX}) ? DELTA_MAX : m[30:0];
	endfunction

endpackage

@@ hw/rtl/motor_run_sample_logger_top.sv @@
// Motor run sample logger top level: handshake, stage 1 and result register.
// Depends on mrsl_pkg, mrsl_ctrl, mrsl_store.
//
//   port group  dir  handshake              payload
//   req         in   req_valid / req_stall  req_t
//   rsp         out  rsp_valid / rsp_stall  rsp_t
//   cfg         in   cfg_write              cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; rsp_valid rises once the item leaves stage 1.
// Stage 1 holds decisions and the registered store read; then the result register.
// Reset clears phase, count and valid flags and loads the config reset values; the store is not cleared.
// A stalled result holds stage 1, and req_stall rises only when both are full.
module motor_run_sample_logger_top
	import mrsl_pkg::*;
#(
	parameter int unsigned DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic          accept;
	logic          advance;
	logic          s1_valid_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_entry_s1;
	meta_t         meta_s1;

	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !advance;
	assign accept    = req_valid && !req_stall;

	mrsl_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.req       (req),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.meta_s1   (meta_s1)
	);

	mrsl_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk         (clk),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_entry    (wr_entry),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_entry_s1 (rd_entry_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.motor_command <= meta_s1.motor_command;
			rsp_q.phase         <= meta_s1.phase;
			rsp_q.sample_stored <= meta_s1.sample_stored;
			rsp_q.sample_count  <= meta_s1.sample_count;
			rsp_q.read_valid    <= meta_s1.read_valid;
			rsp_q.read_time     <= meta_s1.read_valid ? rd_entry_s1.tick_time : 32'd0;
			rsp_q.read_delta    <= meta_s1.read_valid ? rd_entry_s1.delta : 31'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hw/rtl/mrsl_store.sv @@
// Sample store: tick time and position change per entry, registered read.
// Depends on mrsl_pkg (entry_t).
module mrsl_store
	import mrsl_pkg::*;
#(
	parameter int unsigned DEPTH = 2048,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_entry,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_entry_s1
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_s1 <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/mrsl_ctrl.sv @@
// Measurement control: config registers, phase, count and reference registers,
// per-item decisions and store addressing. Depends on mrsl_pkg.
module mrsl_ctrl
	import mrsl_pkg::*;
#(
	parameter int unsigned DEPTH = 2048,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          accept,
	input  req_t          req,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_entry,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output meta_t         meta_s1
);

	logic [31:0] interval_q;
	logic [31:0] startup_q;
	logic [11:0] limit_q;

	logic [1:0]  phase_q;
	logic [11:0] count_q;
	logic [31:0] last_pos_q;
	logic [31:0] last_time_q;
	logic [31:0] start_q;

	logic [1:0]  phase_d;
	logic [11:0] count_d;
	logic        take;
	logic        rvalid;
	logic [1:0]  cmd;
	logic        at_limit;
	logic        due;

	assign at_limit = (count_q >= limit_q) || (32'(count_q) >= 32'(DEPTH));
	assign due      = time_dist(last_time_q, req.tick_time) >= interval_q;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		take    = 1'b0;
		rvalid  = 1'b0;
		cmd     = CMD_NONE;
		case (req.action)
			ACT_START: begin
				phase_d = PH_MEAS;
				count_d = 12'd0;
			end
			ACT_TICK: begin
				if (phase_q == PH_MEAS) begin
					if (req.left_switch || req.right_switch) begin
						phase_d = PH_IDLE;
					end else begin
						cmd = (time_dist(req.tick_time, start_q) <= startup_q) ?
							CMD_BRAKE : CMD_LEFT;
						if (at_limit) begin
							phase_d = PH_DONE;
						end else if (due) begin
							take    = 1'b1;
							count_d = count_q + 12'd1;
						end
					end
				end else if (phase_q == PH_DONE) begin
					cmd     = CMD_BRAKE;
					phase_d = PH_IDLE;
				end
			end
			ACT_READ: begin
				rvalid = ({1'b0, req.read_index} < count_q) &&
					(32'(req.read_index) < 32'(DEPTH));
			end
			default: begin
			end
		endcase
	end

	assign wr_en             = accept && take;
	assign wr_addr           = AW'(32'(count_q));
	assign wr_entry.tick_time = req.tick_time;
	assign wr_entry.delta    = pos_change(req.cart_position, last_pos_q);
	assign rd_en             = accept && rvalid;
	assign rd_addr           = AW'(32'(req.read_index));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RST;
			startup_q   <= STARTUP_RST;
			limit_q     <= LIMIT_RST;
			phase_q     <= PH_IDLE;
			count_q     <= 12'd0;
			last_pos_q  <= 32'd0;
			last_time_q <= 32'd0;
			start_q     <= 32'd0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_INTERVAL: interval_q <= cfg_data;
					REG_STARTUP:  startup_q  <= cfg_data;
					REG_LIMIT:    limit_q    <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				phase_q <= phase_d;
				count_q <= count_d;
				if (req.action == ACT_START) begin
					last_pos_q  <= req.cart_position;
					last_time_q <= req.tick_time;
					start_q     <= req.tick_time;
				end else if (take) begin
					last_pos_q  <= req.cart_position;
					last_time_q <= req.tick_time;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1.motor_command <= cmd;
			meta_s1.phase         <= phase_d;
			meta_s1.sample_stored <= take;
			meta_s1.sample_count  <= count_d;
			meta_s1.read_valid    <= rvalid;
		end
	end

endmodule

@@ test/motor_log_checker.sv @@
`timescale 1ns / 100ps
// Response checker for motor_run_sample_logger_top: follows config writes and accepted
// items, predicts each response and compares it field by field. Depends on mrsl_pkg.
module motor_log_checker
	import mrsl_pkg::*;
#(
	parameter int unsigned DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          stored,
	output int          reads
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [31:0] interval_ticks;
	logic [31:0] startup_ticks;
	logic [11:0] sample_limit;

	logic [1:0]  ph;
	logic [11:0] count;
	logic [31:0] last_pos;
	logic [31:0] last_time;
	logic [31:0] start_time;
	logic [31:0] time_log [DEPTH];
	logic [30:0] delta_log [DEPTH];

	rsp_t awaited_rsp[$];

	// magnitude of a wrapped timer difference; the most negative one gives 2^31
	function automatic logic [31:0] timer_span(input logic [31:0] later,
		input logic [31:0] earlier);
		logic [31:0] diff;
		diff = later - earlier;
		return diff[31] ? ~diff + 32'd1 : diff;
	endfunction

	function automatic logic [30:0] cart_travel(input logic signed [31:0] now_p,
		input logic signed [31:0] old_p);
		longint diff;
		diff = longint'(now_p) - longint'(old_p);
		if (diff < 0) begin
			diff = -diff;
		end
		return (diff > longint'(DELTA_MAX)) ? DELTA_MAX : diff[30:0];
	endfunction

	// advances the logger state by one item and returns its response
	function automatic rsp_t logger_step(input req_t it);
		rsp_t res;
		int unsigned eff_limit;
		res = '0;
		case (it.action)
			ACT_START: begin
				count = '0;
				last_pos = it.cart_position;
				last_time = it.tick_time;
				start_time = it.tick_time;
				ph = PH_MEAS;
			end
			ACT_TICK: begin
				if (ph == PH_MEAS) begin
					if (it.left_switch || it.right_switch) begin
						ph = PH_IDLE;
					end else begin
						eff_limit = (32'(sample_limit) < DEPTH) ? 32'(sample_limit) : DEPTH;
						res.motor_command = (timer_span(it.tick_time, start_time) <= startup_ticks)
							? CMD_BRAKE : CMD_LEFT;
						if (32'(count) >= eff_limit) begin
							ph = PH_DONE;
						end else if (timer_span(last_time, it.tick_time) >= interval_ticks) begin
							time_log[AW'(count)] = it.tick_time;
							delta_log[AW'(count)] = cart_travel(it.cart_position, last_pos);
							last_pos = it.cart_position;
							last_time = it.tick_time;
							count = count + 12'd1;
							res.sample_stored = 1'b1;
						end
					end
				end else if (ph == PH_DONE) begin
					res.motor_command = CMD_BRAKE;
					ph = PH_IDLE;
				end
			end
			ACT_READ: begin
				if (({1'b0, it.read_index} < count) && (32'(it.read_index) < DEPTH)) begin
					res.read_valid = 1'b1;
					res.read_time = time_log[AW'(it.read_index)];
					res.read_delta = delta_log[AW'(it.read_index)];
				end
			end
			default: ;
		endcase
		res.phase = ph;
		res.sample_count = count;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			interval_ticks = INTERVAL_RST;
			startup_ticks = STARTUP_RST;
			sample_limit = LIMIT_RST;
			ph = PH_IDLE;
			count = '0;
			last_pos = '0;
			last_time = '0;
			start_time = '0;
			awaited_rsp.delete();
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_INTERVAL: interval_ticks = cfg_data;
					REG_STARTUP:  startup_ticks = cfg_data;
					REG_LIMIT:    sample_limit = cfg_data[11:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: response with none expected: %h", $time, rsp);
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					compare_field("motor_command", 32'(want.motor_command),
						32'(rsp.motor_command));
					compare_field("phase", 32'(want.phase), 32'(rsp.phase));
					compare_field("sample_stored", 32'(want.sample_stored),
						32'(rsp.sample_stored));
					compare_field("sample_count", 32'(want.sample_count),
						32'(rsp.sample_count));
					compare_field("read_valid", 32'(want.read_valid), 32'(rsp.read_valid));
					compare_field("read_time", want.read_time, rsp.read_time);
					compare_field("read_delta", 32'(want.read_delta), 32'(rsp.read_delta));
					checked++;
				end
			end
			if (req_valid && !req_stall) begin
				want = logger_step(req);
				awaited_rsp.push_back(want);
				stored += int'(want.sample_stored);
				reads += int'(want.read_valid);
			end
			pending = awaited_rsp.size();
		end
	end

endmodule

@@ test/motor_run_sample_logger_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for motor_run_sample_logger_top: clock, reset, register writes and item
// traffic with random idling on both channels. Depends on mrsl_pkg, the block, motor_log_checker.
module motor_run_sample_logger_top_test;
	import mrsl_pkg::*;

	localparam int unsigned STORE_DEPTH = 2048;
	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	int fail_count;
	int pending;
	int checked;
	int stored;
	int reads;
	int quiet_cycles = 0;
	int n_sent = 0;
	bit no_idle = 1'b0;

	motor_run_sample_logger_top #(.DEPTH(STORE_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	motor_log_checker #(.DEPTH(STORE_DEPTH)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked),
		.stored(stored),
		.reads(reads)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no traffic for %0d cycles, %0d responses outstanding",
				$time, quiet_cycles, pending);
			$display("FAIL");
			$finish;
		end
	end

	// response back-pressure
	initial begin
		int r;
		int len;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				rsp_stall <= 1'b0;
				len = $urandom_range(1, 12);
			end else if (r < 65) begin
				rsp_stall <= 1'b0;
				len = $urandom_range(40, 150);
			end else if (r < 94) begin
				rsp_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				rsp_stall <= 1'b1;
				len = $urandom_range(10, 40);
			end
			repeat (len) @(negedge clk);
		end
	end

	function automatic int next_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_item(input logic [1:0] act, input logic [31:0] t,
		input logic [31:0] p, input logic ls, input logic rs);
		req_t it;
		it.action = act;
		it.tick_time = t;
		it.cart_position = p;
		it.left_switch = ls;
		it.right_switch = rs;
		it.read_index = 11'($urandom_range(0, 2047));
		return it;
	endfunction

	function automatic req_t read_item(input logic [10:0] idx);
		req_t it;
		it = make_item(ACT_READ, $urandom, $urandom, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		it.read_index = idx;
		return it;
	endfunction

	function automatic logic [10:0] pick_index();
		return 11'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 2047));
	endfunction

	task automatic send(input req_t item);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// hold the sender until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic configure(input logic [31:0] ivl, input logic [31:0] stp,
		input logic [11:0] lim);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_INTERVAL;
		cfg_data <= ivl;
		@(negedge clk);
		cfg_index <= REG_STARTUP;
		cfg_data <= stp;
		@(negedge clk);
		cfg_index <= REG_LIMIT;
		cfg_data <= {20'd0, lim};
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= $urandom;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// one measurement run: mostly ordered ticks, mixed with reads, restarts and noise
	task automatic run_session(input int n_ops, input int unsigned step_max);
		logic [31:0] t;
		logic [31:0] p;
		int r;
		t = $urandom;
		p = $urandom;
		send(make_item(ACT_START, t, p, 1'b0, 1'b0));
		repeat (n_ops) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				t = t + $urandom_range(0, step_max);
				p = p + $urandom_range(0, 4000) - 2000;
				send(make_item(ACT_TICK, t, p, $urandom_range(0, 99) == 0,
					$urandom_range(0, 99) == 0));
			end else if (r < 83) begin
				send(read_item(pick_index()));
			end else if (r < 87) begin
				send(make_item(ACT_TICK, $urandom, $urandom, 1'b0, 1'b0));
			end else if (r < 91) begin
				t = t + $urandom_range(0, step_max);
				p = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
				send(make_item(ACT_TICK, t, p, 1'b0, 1'b0));
			end else if (r < 93) begin
				send(make_item(ACT_START, t, p, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
			end else if (r < 95) begin
				send(make_item(ACT_NOP, $urandom, $urandom, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
			end else if (r < 97) begin
				drain();
			end else begin
				send(make_item(2'($urandom_range(0, 3)), $urandom, $urandom,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end
		end
	endtask

	initial begin
		logic [31:0] t;
		logic [31:0] p;
		logic [31:0] ivl;
		logic [31:0] stp;
		logic [11:0] lim;
		int unsigned step;
		int n_ops;
		int r;
		int base;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty reads, idle ticks, timer wrap, saturated travel, switches
		send(read_item(11'd2047));
		send(make_item(ACT_TICK, 32'd5, 32'd5, 1'b0, 1'b0));
		send(make_item(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send(make_item(ACT_START, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'h0000_01F0, 32'h8000_0000, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'h0000_01F1, 32'h0000_0000, 1'b0, 1'b0));
		send(read_item(11'd0));
		send(make_item(ACT_TICK, 32'h0000_0400, 32'd7, 1'b1, 1'b0));
		send(make_item(ACT_START, 32'd0, -32'sd5, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd900, 32'd7, 1'b0, 1'b1));
		send(make_item(ACT_TICK, 32'd1900, 32'd7, 1'b0, 1'b0));

		// tight limit: store, restart, done, done tick ignoring switches
		configure(32'd1, 32'd0, 12'd1);
		send(make_item(ACT_START, 32'd100, 32'd10, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd100, 32'd20, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd101, -32'sd20, 1'b0, 1'b0));
		send(make_item(ACT_START, 32'd200, 32'd0, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd201, 32'd3, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd300, 32'd4, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'd301, 32'd4, 1'b1, 1'b1));
		send(read_item(11'd0));
		send(read_item(11'd1));

		// widest settings: half-range timer distance
		configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 12'd2048);
		send(make_item(ACT_START, 32'd0, 32'd0, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'h8000_0000, 32'd1, 1'b0, 1'b0));
		send(make_item(ACT_TICK, 32'h7FFF_FFFF, 32'd2, 1'b0, 1'b0));

		// long run up to its limit, then read its ends
		configure(32'd1, 32'd1000, 12'd1024);
		t = $urandom;
		p = $urandom;
		send(make_item(ACT_START, t, p, 1'b0, 1'b0));
		repeat (1025) begin
			t = t + $urandom_range(1, 3);
			p = ($urandom_range(0, 15) == 0) ? $urandom : p + $urandom_range(0, 200) - 100;
			send(make_item(ACT_TICK, t, p, 1'b0, 1'b0));
		end
		send(read_item(11'd1023));
		send(read_item(11'd1024));
		send(read_item(11'd0));
		repeat (6) send(read_item(11'($urandom_range(0, 2047))));
		send(make_item(ACT_TICK, t, p, 1'b0, 1'b0));
		send(read_item(11'd1023));

		base = n_sent;
		while (n_sent - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) ivl = 32'd1;
			else if (r < 15) ivl = 32'hFFFF_FFFF;
			else if (r < 25) ivl = $urandom;
			else ivl = $urandom_range(2, 50);
			step = (ivl <= 32'd5000) ? 2 * ivl + 1 : 32'hFFFF_FFFF;
			r = $urandom_range(0, 99);
			if (r < 15) stp = 32'd0;
			else if (r < 25) stp = 32'hFFFF_FFFF;
			else if (r < 35 || step > 20001) stp = $urandom;
			else stp = $urandom_range(0, 20 * step);
			r = $urandom_range(0, 99);
			if (r < 15) lim = 12'd1;
			else if (r < 22) lim = 12'd2048;
			else lim = 12'($urandom_range(2, 25));
			n_ops = (lim > 12'd40) ? $urandom_range(30, 80) : 2 * lim + $urandom_range(4, 24);
			configure(ivl, stp, lim);
			no_idle = ($urandom_range(0, 3) == 0);
			run_session(n_ops, step);
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Run covered %0d items over many register settings, %0d responses checked",
			n_sent, checked);
		$display("Stored samples seen: %0d, valid reads seen: %0d", stored, reads);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
